[rtl/lspwe_pkg.sv]
// ----------------------------------------------------------------------------
// lspwe_pkg
// Shared types and constants of the LED strip pulse width encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lspwe_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int LEVEL_W    = 8;
    localparam int COUNT_W    = 8;
    localparam int TICK_W     = 8;
    localparam int RSLOT_W    = 10;
    localparam int STRIP_W    = 11;
    localparam int SLOT_W     = 15;
    localparam int GRB_W      = 24;
    localparam int COLOR_BITS = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH  = 3'd0,
        CFG_ONE_HIGH   = 3'd1,
        CFG_BIT_PERIOD = 3'd2,
        CFG_RESET_SLOT = 3'd3,
        CFG_STRIP_LEN  = 3'd4
    } t_cfg_idx;

    localparam logic [TICK_W-1:0]  ZERO_HIGH_RST  = 8'd29;
    localparam logic [TICK_W-1:0]  ONE_HIGH_RST   = 8'd58;
    localparam logic [TICK_W-1:0]  BIT_PERIOD_RST = 8'd90;
    localparam logic [RSLOT_W-1:0] RESET_SLOT_RST = 10'd280;
    localparam logic [STRIP_W-1:0] STRIP_LEN_RST  = 11'd12;

endpackage

`default_nettype wire

[rtl/lspwe_in_if.sv]
// ----------------------------------------------------------------------------
// lspwe_in_if
// Request channel: tick or start frame beat with count and color.
// ----------------------------------------------------------------------------
`default_nettype none

interface lspwe_in_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [lspwe_pkg::COUNT_W-1:0]    active_count;
    logic [lspwe_pkg::LEVEL_W-1:0]    red_level;
    logic [lspwe_pkg::LEVEL_W-1:0]    green_level;
    logic [lspwe_pkg::LEVEL_W-1:0]    blue_level;

    modport source (
        output valid, req_type, active_count, red_level, green_level, blue_level,
        input  ready
    );
    modport sink (
        input  valid, req_type, active_count, red_level, green_level, blue_level,
        output ready
    );
endinterface

`default_nettype wire

[rtl/lspwe_out_if.sv]
// ----------------------------------------------------------------------------
// lspwe_out_if
// Result channel: line level and frame status for one request beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lspwe_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_taken;

    modport source (
        output valid, line_level, busy_res, frame_done, start_taken,
        input  ready
    );
    modport sink (
        input  valid, line_level, busy_res, frame_done, start_taken,
        output ready
    );
endinterface

`default_nettype wire

[rtl/lspwe_cfg_if.sv]
// ----------------------------------------------------------------------------
// lspwe_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lspwe_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lspwe_pkg::CFG_IDX_W-1:0]     index;
    logic [lspwe_pkg::CFG_DATA_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/led_strip_pulse_width_encoder.sv]
// ----------------------------------------------------------------------------
// led_strip_pulse_width_encoder
// Pulse width bit encoder for a single-wire addressable LED strip.
//
// i_in carries one beat per timer tick (req_type 0) or a start frame request
// (req_type 1) with active LED count and color. A start latches count and
// color and is ignored while a frame runs. Each tick beat advances the
// waveform: leading reset slots (line low), BITS_PER_LED bit slots per LED
// sent green, red, blue msb first, then trailing reset slots.
// o_out returns exactly one result beat per request beat: line level of the
// tick, busy, frame done and start taken.
// i_cfg writes the timing and strip registers, one register per beat, and is
// always ready; writes take effect on the next tick.
// Each result beat is registered from its request beat; one request beat is
// taken every cycle unless o_out stalls. The slot decode, frame end compare
// and line level are one pass of logic between the state registers and the
// result register. While o_out is stalled the result register holds and
// i_in takes one more beat only once the held result is taken.
// Reset loads the register defaults, clears the frame state and empties the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_pulse_width_encoder #(
    parameter int MAX_LEDS     = 1024,
    parameter int BITS_PER_LED = 24
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lspwe_in_if.sink     i_in,
    lspwe_out_if.source  o_out,
    lspwe_cfg_if.sink    i_cfg
);

    localparam int TICK_W   = lspwe_pkg::TICK_W;
    localparam int RSLOT_W  = lspwe_pkg::RSLOT_W;
    localparam int STRIP_W  = lspwe_pkg::STRIP_W;
    localparam int SLOT_W   = lspwe_pkg::SLOT_W;
    localparam int GRB_W    = lspwe_pkg::GRB_W;
    localparam int STRIP_MAX = (1 << STRIP_W) - 1;
    localparam int MAX_FIT  = (MAX_LEDS > STRIP_MAX) ? STRIP_MAX : MAX_LEDS;
    localparam int DATA_MAX = MAX_FIT * BITS_PER_LED;
    localparam int DATA_W   = $clog2(DATA_MAX + 1);
    localparam int TOT_W    = $clog2(2 * ((1 << RSLOT_W) - 1) + DATA_MAX + 1);
    localparam int CMP_W    = TOT_W > SLOT_W ? TOT_W + 1 : SLOT_W + 1;
    localparam int BIT_W    = $clog2(BITS_PER_LED);
    localparam int BPL_W    = $clog2(BITS_PER_LED + 1);
    localparam int PROD_W   = 2 * STRIP_W + 2;
    localparam int RECIP_SH = SLOT_W + BPL_W;
    localparam int RECIP    = ((1 << RECIP_SH) + BITS_PER_LED - 1) / BITS_PER_LED;
    localparam int MUL_W    = SLOT_W + $clog2(RECIP + 1);
    localparam int LED_W    = MUL_W - RECIP_SH;
    localparam int GIDX_W   = $clog2(GRB_W);

    localparam logic [STRIP_W-1:0] C_MAX_FIT = STRIP_W'(MAX_FIT);
    localparam logic [BPL_W-1:0]   C_BPL     = BPL_W'(BITS_PER_LED);

    // configuration registers
    logic [TICK_W-1:0]  r_zero_high;
    logic [TICK_W-1:0]  r_one_high;
    logic [TICK_W-1:0]  r_bit_period;
    logic [RSLOT_W-1:0] r_reset_slots;
    logic [STRIP_W-1:0] r_strip_len;

    // frame state
    logic               r_sending,   n_sending;
    logic [TICK_W-1:0]  r_tick,      n_tick;
    logic [SLOT_W-1:0]  r_slot,      n_slot;
    logic [STRIP_W-1:0] r_lat_count, n_lat_count;
    logic [GRB_W-1:0]   r_grb,       n_grb;

    // result register
    logic r_out_valid;
    logic r_line,  n_line;
    logic r_busy,  n_busy;
    logic r_done,  n_done;
    logic r_taken, n_taken;

    logic in_ready;
    logic in_acc;

    logic               strip_over;
    logic [STRIP_W-1:0] eff_strip;
    logic [DATA_W-1:0]  data_slots;
    logic [TOT_W-1:0]   total_slots;
    logic               below_reset;
    logic [SLOT_W-1:0]  rel;
    logic               in_data;
    logic [MUL_W-1:0]   prod;
    logic [LED_W-1:0]   led;
    logic [SLOT_W-1:0]  bit_full;
    logic [BIT_W-1:0]   bit_idx;
    logic               in_color;
    logic [GIDX_W-1:0]  grb_idx;
    logic               bit_one;
    logic [TICK_W-1:0]  high_ticks;
    logic               line_now;
    logic [TICK_W-1:0]  period;
    logic [TICK_W-1:0]  tick_inc;
    logic [SLOT_W-1:0]  slot_inc;
    logic               end_now;
    logic               end_next;
    logic [STRIP_W-1:0] req_count;

    assign in_ready    = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.line_level  = r_line;
    assign o_out.busy_res    = r_busy;
    assign o_out.frame_done  = r_done;
    assign o_out.start_taken = r_taken;

    // frame geometry from live registers
    always_comb begin
        strip_over  = 32'(r_strip_len) > 32'(MAX_LEDS);
        eff_strip   = strip_over ? C_MAX_FIT : r_strip_len;
        data_slots  = DATA_W'(PROD_W'(eff_strip) * PROD_W'(C_BPL));
        total_slots = TOT_W'(CMP_W'({r_reset_slots, 1'b0}) + CMP_W'(data_slots));
    end

    // slot decode and line level
    always_comb begin
        below_reset = r_slot < SLOT_W'(r_reset_slots);
        rel         = r_slot - SLOT_W'(r_reset_slots);
        in_data     = !below_reset && (CMP_W'(rel) < CMP_W'(data_slots));
        prod        = MUL_W'(rel) * MUL_W'(RECIP);
        led         = prod[MUL_W-1:RECIP_SH];
        bit_full    = rel - SLOT_W'(MUL_W'(led) * MUL_W'(C_BPL));
        bit_idx     = bit_full[BIT_W-1:0];
        in_color    = 32'(bit_idx) < 32'(lspwe_pkg::COLOR_BITS);
        grb_idx     = GIDX_W'(GRB_W - 1) - GIDX_W'(bit_idx);
        bit_one     = in_data && (32'(led) < 32'(r_lat_count)) && in_color
                      && (in_color ? r_grb[grb_idx] : 1'b0);
        high_ticks  = bit_one ? r_one_high : r_zero_high;
        line_now    = in_data && (r_tick < high_ticks);
    end

    // next state and result
    always_comb begin
        period    = (r_bit_period == '0) ? TICK_W'(1) : r_bit_period;
        tick_inc  = r_tick + TICK_W'(1);
        slot_inc  = r_slot + SLOT_W'(1);
        end_now   = CMP_W'(r_slot) >= CMP_W'(total_slots);
        end_next  = CMP_W'(slot_inc) >= CMP_W'(total_slots);
        req_count = (STRIP_W'(i_in.active_count) > eff_strip) ? eff_strip
                                                              : STRIP_W'(i_in.active_count);

        n_sending   = r_sending;
        n_tick      = r_tick;
        n_slot      = r_slot;
        n_lat_count = r_lat_count;
        n_grb       = r_grb;
        n_line      = 1'b0;
        n_busy      = 1'b0;
        n_done      = 1'b0;
        n_taken     = 1'b0;

        if (i_in.req_type) begin
            n_busy = 1'b1;
            if (!r_sending) begin
                n_lat_count = req_count;
                n_grb       = {i_in.green_level, i_in.red_level, i_in.blue_level};
                n_sending   = 1'b1;
                n_tick      = '0;
                n_slot      = '0;
                n_taken     = 1'b1;
            end
        end else if (r_sending) begin
            n_busy = 1'b1;
            if (end_now) begin
                n_sending = 1'b0;
                n_done    = 1'b1;
                n_tick    = '0;
            end else begin
                n_line = line_now;
                if (tick_inc >= period) begin
                    n_tick = '0;
                    n_slot = slot_inc;
                    if (end_next) begin
                        n_sending = 1'b0;
                        n_done    = 1'b1;
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_high   <= lspwe_pkg::ZERO_HIGH_RST;
            r_one_high    <= lspwe_pkg::ONE_HIGH_RST;
            r_bit_period  <= lspwe_pkg::BIT_PERIOD_RST;
            r_reset_slots <= lspwe_pkg::RESET_SLOT_RST;
            r_strip_len   <= lspwe_pkg::STRIP_LEN_RST;
        end else if (i_cfg.valid) begin
            unique case (lspwe_pkg::t_cfg_idx'(i_cfg.index))
                lspwe_pkg::CFG_ZERO_HIGH:  r_zero_high   <= i_cfg.data[TICK_W-1:0];
                lspwe_pkg::CFG_ONE_HIGH:   r_one_high    <= i_cfg.data[TICK_W-1:0];
                lspwe_pkg::CFG_BIT_PERIOD: r_bit_period  <= i_cfg.data[TICK_W-1:0];
                lspwe_pkg::CFG_RESET_SLOT: r_reset_slots <= i_cfg.data[RSLOT_W-1:0];
                lspwe_pkg::CFG_STRIP_LEN:  r_strip_len   <= i_cfg.data[STRIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_tick      <= '0;
            r_slot      <= '0;
            r_lat_count <= '0;
            r_grb       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_sending   <= n_sending;
                r_tick      <= n_tick;
                r_slot      <= n_slot;
                r_lat_count <= n_lat_count;
                r_grb       <= n_grb;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line  <= n_line;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_taken <= n_taken;
        end
    end

    // a frame ends only on a tick beat
    a_end_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_sending) |-> $past(in_acc) && !$past(i_in.req_type))
        else $error("frame ended without a tick beat");

    // a frame starts only on an accepted start beat
    a_start_on_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sending) |-> $past(in_acc) && $past(i_in.req_type))
        else $error("frame started without a start beat");

    // a taken start rewinds the waveform position
    a_start_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.req_type && !r_sending |=>
            r_sending && (r_slot == '0) && (r_tick == '0) && o_out.start_taken)
        else $error("start beat did not rewind the frame");

    // start result never carries line or done
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_taken |-> r_busy && !r_line && !r_done)
        else $error("start result carries tick fields");

    // done and busy are raised together
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_done |=> r_busy && !r_sending)
        else $error("frame done without busy");

endmodule

`default_nettype wire
